### src/i2cms_pkg.sv
// Package for the I2C master byte sequencer: widths, command codes, step encoding.
package i2cms_pkg;

    localparam int ACTION_W = 3;
    localparam int ADDR_W   = 7;
    localparam int BYTE_W   = 8;
    localparam int BIT_CNT_W = 4;
    localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK  = 3'd0,
        ACT_START = 3'd1,
        ACT_WRITE = 3'd2,
        ACT_READ  = 3'd3,
        ACT_STOP  = 3'd4
    } action_t;

    typedef enum logic [20:0] {
        ST_IDLE = 21'h000001,
        ST_S0   = 21'h000002,
        ST_S1   = 21'h000004,
        ST_B0   = 21'h000008,
        ST_B1   = 21'h000010,
        ST_B2   = 21'h000020,
        ST_B3   = 21'h000040,
        ST_B4   = 21'h000080,
        ST_B5   = 21'h000100,
        ST_B6   = 21'h000200,
        ST_R0   = 21'h000400,
        ST_R1   = 21'h000800,
        ST_R2   = 21'h001000,
        ST_R3   = 21'h002000,
        ST_R4   = 21'h004000,
        ST_R5   = 21'h008000,
        ST_R6   = 21'h010000,
        ST_R7   = 21'h020000,
        ST_T0   = 21'h040000,
        ST_T1   = 21'h080000,
        ST_T2   = 21'h100000
    } step_t;

    // steps that hold for half_period ticks
    function automatic logic step_waits(step_t st);
        logic w;
        unique case (st)
            ST_S0, ST_B1, ST_B2, ST_B4, ST_B5,
            ST_R1, ST_R2, ST_R5, ST_R6,
            ST_T0, ST_T1, ST_T2: w = 1'b1;
            default:             w = 1'b0;
        endcase
        return w;
    endfunction

    // default successor in the step sequence
    function automatic step_t step_succ(step_t st);
        step_t nx;
        unique case (st)
            ST_S0:   nx = ST_S1;
            ST_S1:   nx = ST_B0;
            ST_B0:   nx = ST_B1;
            ST_B1:   nx = ST_B2;
            ST_B2:   nx = ST_B3;
            ST_B3:   nx = ST_B4;
            ST_B4:   nx = ST_B5;
            ST_B5:   nx = ST_B6;
            ST_R0:   nx = ST_R1;
            ST_R1:   nx = ST_R2;
            ST_R2:   nx = ST_R3;
            ST_R3:   nx = ST_R4;
            ST_R4:   nx = ST_R5;
            ST_R5:   nx = ST_R6;
            ST_R6:   nx = ST_R7;
            ST_T0:   nx = ST_T1;
            ST_T1:   nx = ST_T2;
            default: nx = ST_IDLE;
        endcase
        return nx;
    endfunction

endpackage

### src/i2c_master_byte_sequencer.sv
// Top level: tick-paced open-drain I2C master command sequencer.
//
// Requests enter on in_valid/in_ready. Each request is a tick (action 0) or a
// command: start plus address, write byte, read byte, stop. A command taken while
// idle is latched and raises busy; later ticks walk the pin sequence, each wait
// lasting half_period ticks. A command taken while busy is reported as rejected.
// Every request yields one result on out_valid/out_ready: pin levels, busy,
// done, ack status, last read byte and the reject flag.
// Latency: the result is registered at the edge that takes the request and is
// offered on the next cycle. Throughput: one request per clock while results are
// taken; the step state and result register update in a single pass. A stalled
// receiver holds the result register; in_ready follows !out_valid || out_ready,
// so a new request is taken in the same cycle as the waiting result leaves.
// Users write half_period via cfg_we/cfg_wdata only while idle; not enforced here.
// Reset: idle, both lines released, half_period = 1, no result pending.
module i2c_master_byte_sequencer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [i2cms_pkg::BYTE_W-1:0]  cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [i2cms_pkg::ACTION_W-1:0] action,
    input  logic [i2cms_pkg::ADDR_W-1:0]  address,
    input  logic                          read_bit,
    input  logic [i2cms_pkg::BYTE_W-1:0]  data_byte,
    input  logic                          last_byte,
    input  logic                          sda_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          scl_release,
    output logic                          sda_release,
    output logic                          busy_res,
    output logic                          done_res,
    output logic                          ack_ok,
    output logic [i2cms_pkg::BYTE_W-1:0]  read_data,
    output logic                          rejected
);
    import i2cms_pkg::*;

    logic [BYTE_W-1:0]    half_period_reg;
    step_t                step_reg, step_next;
    logic [BIT_CNT_W-1:0] bit_count_reg, bit_count_next;
    logic [BYTE_W-1:0]    wait_count_reg, wait_count_next;
    logic [BYTE_W-1:0]    shift_reg, shift_next;
    logic                 nack_reg, nack_next;
    logic                 ack_reg, ack_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic [BYTE_W-1:0]    read_hold_reg, read_hold_next;
    logic                 out_valid_reg;
    logic                 done_reg, done_next;
    logic                 rej_reg, rej_next;

    logic                 accept;
    logic                 is_cmd;
    logic                 waits;
    logic [BYTE_W:0]      wait_inc;
    logic [BYTE_W-1:0]    hp;
    logic                 apply_pins;
    logic                 finish;
    logic [BIT_CNT_W-1:0] bit_inc;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign is_cmd = (action == ACT_START) || (action == ACT_WRITE) ||
                    (action == ACT_READ)  || (action == ACT_STOP);
    assign waits      = step_waits(step_reg);
    assign wait_inc   = {1'b0, wait_count_reg} + {{BYTE_W{1'b0}}, 1'b1};
    assign hp         = (half_period_reg == '0) ? {{(BYTE_W-1){1'b0}}, 1'b1}
                                                : half_period_reg;
    assign apply_pins = waits ? (wait_count_reg == '0) : 1'b1;
    assign finish     = waits ? (wait_inc >= {1'b0, hp}) : 1'b1;
    assign bit_inc    = bit_count_reg + {{(BIT_CNT_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        step_next       = step_reg;
        bit_count_next  = bit_count_reg;
        wait_count_next = wait_count_reg;
        shift_next      = shift_reg;
        nack_next       = nack_reg;
        ack_next        = ack_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        read_hold_next  = read_hold_reg;
        done_next       = 1'b0;
        rej_next        = 1'b0;

        if (is_cmd)
        begin
            if (step_reg != ST_IDLE)
            begin
                rej_next = 1'b1;
            end
            else
            begin
                bit_count_next  = '0;
                wait_count_next = '0;
                unique case (action)
                    ACT_START:
                    begin
                        shift_next = {address, read_bit};
                        step_next  = ST_S0;
                    end
                    ACT_WRITE:
                    begin
                        shift_next = data_byte;
                        step_next  = ST_B0;
                    end
                    ACT_READ:
                    begin
                        shift_next = '0;
                        nack_next  = last_byte;
                        step_next  = ST_R0;
                    end
                    default:
                    begin
                        step_next = ST_T0;
                    end
                endcase
            end
        end
        else if (step_reg != ST_IDLE)
        begin
            if (waits)
            begin
                wait_count_next = wait_inc[BYTE_W-1:0];
            end

            if (apply_pins)
            begin
                unique case (step_reg)
                    ST_S0, ST_B6, ST_R7, ST_T0:        sda_next = 1'b0;
                    ST_S1, ST_B2, ST_B5, ST_R3, ST_R6: scl_next = 1'b0;
                    ST_B0:  sda_next = shift_reg[3'd7 - bit_count_reg[2:0]];
                    ST_B1, ST_B4, ST_R2, ST_R5, ST_T1: scl_next = 1'b1;
                    ST_B3, ST_R0, ST_T2:               sda_next = 1'b1;
                    ST_R4:  sda_next = nack_reg;
                    default: ;
                endcase
            end

            if (finish)
            begin
                wait_count_next = '0;
                step_next       = step_succ(step_reg);
                unique case (step_reg)
                    ST_S1:
                    begin
                        bit_count_next = '0;
                    end
                    ST_B2:
                    begin
                        bit_count_next = bit_inc;
                        step_next = (bit_inc < BITS_PER_BYTE) ? ST_B0 : ST_B3;
                    end
                    ST_B4:
                    begin
                        ack_next = !sda_in;
                    end
                    ST_R2:
                    begin
                        shift_next = {shift_reg[BYTE_W-2:0], sda_in};
                    end
                    ST_R3:
                    begin
                        bit_count_next = bit_inc;
                        step_next = (bit_inc < BITS_PER_BYTE) ? ST_R1 : ST_R4;
                    end
                    ST_R7:
                    begin
                        read_hold_next = shift_reg;
                        done_next      = 1'b1;
                    end
                    ST_B6, ST_T2:
                    begin
                        done_next = 1'b1;
                    end
                    default: ;
                endcase
                if (done_next)
                begin
                    step_next      = ST_IDLE;
                    bit_count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= {{(BYTE_W-1){1'b0}}, 1'b1};
            step_reg        <= ST_IDLE;
            bit_count_reg   <= '0;
            wait_count_reg  <= '0;
            shift_reg       <= '0;
            nack_reg        <= 1'b0;
            ack_reg         <= 1'b0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            read_hold_reg   <= '0;
            out_valid_reg   <= 1'b0;
            done_reg        <= 1'b0;
            rej_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                half_period_reg <= cfg_wdata;
            end
            if (accept)
            begin
                step_reg       <= step_next;
                bit_count_reg  <= bit_count_next;
                wait_count_reg <= wait_count_next;
                shift_reg      <= shift_next;
                nack_reg       <= nack_next;
                ack_reg        <= ack_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
                read_hold_reg  <= read_hold_next;
                done_reg       <= done_next;
                rej_reg        <= rej_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign scl_release = scl_reg;
    assign sda_release = sda_reg;
    assign busy_res    = (step_reg != ST_IDLE);
    assign done_res    = done_reg;
    assign ack_ok      = ack_reg;
    assign read_data   = read_hold_reg;
    assign rejected    = rej_reg;

endmodule
